FILE: design/srrw_pkg.sv
package srrw_pkg;

  localparam int SEQ_COUNT_DEF = 20;
  localparam logic [4:0] WINDOW_SIZE_RST = 5'd10;

  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] seq_id;
  } pkt_t;

  typedef struct packed {
    logic [7:0] ack_seq;
    logic       accepted;
    logic [4:0] base_after;
    logic [4:0] released_count;
  } ack_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_SLIDE,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_DIST,
    OP_INC
  } alu_op_t;

  typedef struct packed {
    logic set_one;
    logic clr_one;
    logic clr_all;
  } mark_ctl_t;

endpackage

FILE: design/srrw_alu.sv
// Shared modular unit: (a - b) mod N or (a + 1) mod N, one adder.
module srrw_alu #(
  parameter int SEQ_COUNT = srrw_pkg::SEQ_COUNT_DEF,
  parameter int SLOT_W    = $clog2(SEQ_COUNT)
) (
  input  srrw_pkg::alu_op_t   op,
  input  logic [SLOT_W-1:0]   a,
  input  logic [SLOT_W-1:0]   b,
  output logic [SLOT_W-1:0]   res
);

  localparam logic [SLOT_W:0] N_EXT = (SLOT_W + 1)'(SEQ_COUNT);

  logic [SLOT_W:0] opnd;
  logic [SLOT_W:0] sum;
  logic [SLOT_W:0] fix;

  always_comb begin
    opnd = (op == srrw_pkg::OP_DIST) ? ~{1'b0, b} : '0;
    sum  = {1'b0, a} + opnd + (SLOT_W + 1)'(1);
    fix  = sum;
    if (op == srrw_pkg::OP_DIST) begin
      // borrow out: wrap around the sequence space
      if (sum[SLOT_W]) begin
        fix = sum + N_EXT;
      end
    end else if (sum == N_EXT) begin
      fix = '0;
    end
    res = fix[SLOT_W-1:0];
  end

endmodule

FILE: design/srrw_marks.sv
// Received-slot marks, one flop per slot, read at one address.
module srrw_marks #(
  parameter int SEQ_COUNT = srrw_pkg::SEQ_COUNT_DEF,
  parameter int SLOT_W    = $clog2(SEQ_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  input  srrw_pkg::mark_ctl_t ctl,
  input  logic [SLOT_W-1:0]   addr,
  output logic                rd
);

  logic [SEQ_COUNT-1:0] marks;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      marks <= '0;
    end else if (ctl.set_one) begin
      marks[addr] <= 1'b1;
    end else if (ctl.clr_one) begin
      marks[addr] <= 1'b0;
    end
  end

  assign rd = marks[addr];

endmodule

FILE: design/selective_repeat_receiver_window.sv
// Flow: an in-range data packet passes the window check (DIST) and EMIT before the
//   result register loads; a clear or a rejected number goes straight to EMIT; a packet
//   that fills the base slot also passes SLIDE, which releases marked slots, before EMIT.
// No new packet is taken until the last result is loaded; the slide walks one mark per
//   cycle through the shared modular unit, which also does the distance.
// Reset (synchronous, active high): marks cleared, base 0, window_size 10, no result.
module selective_repeat_receiver_window #(
  parameter int SEQ_COUNT = srrw_pkg::SEQ_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // window_size register write
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [4:0]     cfg_data,
  // packet channel
  input  logic           pkt_valid,
  output logic           pkt_stall,
  input  srrw_pkg::pkt_t pkt,
  // acknowledge channel
  output logic           ack_valid,
  input  logic           ack_stall,
  output srrw_pkg::ack_t ack
);

  localparam int SLOT_W = $clog2(SEQ_COUNT);
  localparam int CNT_W  = $clog2(SEQ_COUNT + 1);
  localparam int CW     = SLOT_W + 5;
  localparam logic [8:0] SEQ_MAX = 9'(SEQ_COUNT);

  srrw_pkg::state_t    state;
  srrw_pkg::state_t    state_next;
  srrw_pkg::mark_ctl_t mark_ctl;
  srrw_pkg::alu_op_t   alu_op;

  logic [4:0]        wsize;
  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] idx;      // packet slot, then slide position
  logic [CNT_W-1:0]  cnt;      // slots released so far
  logic [7:0]        seq_q;
  logic              acc_q;

  logic [SLOT_W-1:0] alu_res;
  logic              mark_rd;
  logic              accept;
  logic              seq_ok;
  logic              in_win;
  logic              cnt_lt_n;
  logic              slide_end;
  logic              load_res;
  logic [7:0]        seq_m1;
  logic [CW-1:0]     base_ext;
  logic [CNT_W+4:0]  cnt_ext;

  srrw_alu #(
    .SEQ_COUNT (SEQ_COUNT),
    .SLOT_W    (SLOT_W)
  ) u_alu (
    .op  (alu_op),
    .a   (idx),
    .b   (base),
    .res (alu_res)
  );

  srrw_marks #(
    .SEQ_COUNT (SEQ_COUNT),
    .SLOT_W    (SLOT_W)
  ) u_marks (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mark_ctl),
    .addr (idx),
    .rd   (mark_rd)
  );

  // config is taken at any time; the host is to write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  assign pkt_stall = (state != srrw_pkg::ST_IDLE);
  assign accept    = pkt_valid && !pkt_stall;

  // sequence numbers are 1-based; 0 and anything above the count are rejected
  assign seq_ok   = (pkt.seq_id != 8'd0) && ({1'b0, pkt.seq_id} <= SEQ_MAX);
  assign seq_m1   = pkt.seq_id - 8'd1;
  // in DIST the shared unit gives (slot - base) mod N
  assign in_win   = CW'(alu_res) < CW'(wsize);
  // full wrap guard: slide stops after every slot has been passed once
  assign cnt_lt_n = cnt < CNT_W'(SEQ_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srrw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mark_ctl   = '0;
    alu_op     = srrw_pkg::OP_INC;
    slide_end  = 1'b0;
    load_res   = 1'b0;
    case (state)
      srrw_pkg::ST_IDLE: begin
        if (accept) begin
          if (pkt.func == srrw_pkg::FUNC_CLEAR) begin
            mark_ctl.clr_all = 1'b1;
            state_next       = srrw_pkg::ST_EMIT;
          end else if (seq_ok) begin
            state_next = srrw_pkg::ST_DIST;
          end else begin
            state_next = srrw_pkg::ST_EMIT;
          end
        end
      end
      srrw_pkg::ST_DIST: begin
        alu_op = srrw_pkg::OP_DIST;
        if (in_win) begin
          mark_ctl.set_one = 1'b1;
          state_next = (idx == base) ? srrw_pkg::ST_SLIDE : srrw_pkg::ST_EMIT;
        end else begin
          state_next = srrw_pkg::ST_EMIT;
        end
      end
      srrw_pkg::ST_SLIDE: begin
        alu_op = srrw_pkg::OP_INC;
        if (mark_rd && cnt_lt_n) begin
          mark_ctl.clr_one = 1'b1;
        end else begin
          slide_end  = 1'b1;
          state_next = srrw_pkg::ST_EMIT;
        end
      end
      srrw_pkg::ST_EMIT: begin
        // wait for the result register to free up
        if (!ack_valid || !ack_stall) begin
          load_res   = 1'b1;
          state_next = srrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srrw_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wsize     <= srrw_pkg::WINDOW_SIZE_RST;
      base      <= '0;
      ack_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wsize <= cfg_data;
      end
      if (accept && pkt.func == srrw_pkg::FUNC_CLEAR) begin
        base <= '0;
      end else if (slide_end) begin
        base <= idx;
      end
      if (load_res) begin
        ack_valid <= 1'b1;
      end else if (!ack_stall) begin
        ack_valid <= 1'b0;
      end
    end
  end

  // per-packet working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q <= (pkt.func == srrw_pkg::FUNC_CLEAR) ? 8'd0 : pkt.seq_id;
      acc_q <= 1'b0;
      cnt   <= '0;
      idx   <= seq_m1[SLOT_W-1:0];
    end else begin
      if (state == srrw_pkg::ST_DIST && in_win) begin
        acc_q <= 1'b1;
      end
      if (mark_ctl.clr_one) begin
        idx <= alu_res;
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // output fields are 5 bits; widen first so any SEQ_COUNT folds cleanly
  assign base_ext = CW'(base);
  assign cnt_ext  = (CNT_W + 5)'(cnt);

  always_ff @(posedge clk) begin
    if (load_res) begin
      ack.ack_seq        <= seq_q;
      ack.accepted       <= acc_q;
      ack.base_after     <= base_ext[4:0];
      ack.released_count <= cnt_ext[4:0];
    end
  end

  // a rejected or out-of-window packet never releases slots
  a_reject_no_release: assert property (@(posedge clk) disable iff (rst)
    ack_valid && !ack.accepted |-> ack.released_count == 5'd0)
    else $error("released slots on a packet that was not accepted");

  // the slide never passes more slots than the sequence space holds
  a_slide_bound: assert property (@(posedge clk) disable iff (rst)
    state == srrw_pkg::ST_SLIDE |-> cnt <= CNT_W'(SEQ_COUNT))
    else $error("slide count ran past the sequence count");

  // base stays a legal slot
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    CW'(base) < CW'(SEQ_COUNT))
    else $error("window base out of range");

  // a pending result is never overwritten while the consumer stalls
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    state == srrw_pkg::ST_EMIT && ack_valid && ack_stall |=> state == srrw_pkg::ST_EMIT)
    else $error("result register loaded while stalled");

endmodule
